// ----- src/hufd_pkg.sv -----
// ============================================================================
// hufd_pkg
// Shared constants and control structs of the preorder-header decoder.
// ============================================================================
package hufd_pkg;

    // Default table sizes
    localparam int NODE_COUNT_DEF  = 512;
    localparam int STACK_DEPTH_DEF = 256;

    // Byte handling
    localparam int         BYTE_W    = 8;
    localparam logic [7:0] LEAF_FLAG = 8'h4C;   // 'L'

    // Bit counter for the serial walk over one coded byte
    localparam int                 BIT_CNT_W = 3;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT  = 3'd7;

    // File phase codes
    localparam logic [1:0] PH_FLAG   = 2'd0;   // expecting a header flag byte
    localparam logic [1:0] PH_SYM    = 2'd1;   // expecting a leaf symbol byte
    localparam logic [1:0] PH_DECODE = 2'd2;   // coded data
    localparam logic [1:0] PH_HALT   = 2'd3;   // header overflowed, wait for restart

    // Command to the header parser
    typedef struct packed {
        logic start;    // one header byte to process
        logic clear;    // new file: forget tree and stack first
        logic is_sym;   // byte is a leaf symbol, not a flag
    } t_hdr_cmd;

    // Status from the header parser
    typedef struct packed {
        logic       done;    // pulse: byte fully processed
        logic       error;   // node table or stack overflow
        logic [1:0] phase;   // phase that follows the byte
    } t_hdr_stat;

    // Field write enables into the node table
    typedef struct packed {
        logic leaf;
        logic left;
        logic right;
        logic sym;
    } t_node_we;

endpackage

// ----- src/hufd_hdr.sv -----
// ============================================================================
// hufd_hdr
// Preorder tree header parser: allocates nodes, links them to parent slots
// taken from a pending-slot stack, and drives node table writes.
// ============================================================================
module hufd_hdr #(
    parameter int NODE_COUNT  = hufd_pkg::NODE_COUNT_DEF,
    parameter int STACK_DEPTH = hufd_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hufd_pkg::t_hdr_cmd            i_cmd,
    input  logic [hufd_pkg::BYTE_W-1:0]   i_data,
    output hufd_pkg::t_hdr_stat           o_stat,
    output hufd_pkg::t_node_we            o_we,
    output logic [$clog2(NODE_COUNT)-1:0] o_waddr,
    output logic [$clog2(NODE_COUNT)-1:0] o_wchild,
    output logic                          o_wleaf,
    output logic [hufd_pkg::BYTE_W-1:0]   o_wsym
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int NUW = $clog2(NODE_COUNT + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int PCW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] H_IDLE  = 2'd0;
    localparam logic [1:0] H_LINK  = 2'd1;
    localparam logic [1:0] H_PUSH1 = 2'd2;
    localparam logic [1:0] H_PUSH2 = 2'd3;

    logic [1:0]          r_state;
    logic [NUW-1:0]      r_nodes_used;
    logic [PCW-1:0]      r_pcount;
    logic [NW-1:0]       r_node;
    logic                r_leaf;
    hufd_pkg::t_hdr_stat r_stat;

    // Pending slots: {parent node, side}, side 1 = right
    logic [NW:0] r_stack [STACK_DEPTH];
    logic [NW:0] r_stk_rd;

    logic [NUW-1:0] n_eff;
    logic [NUW-1:0] n_eff_m1;
    logic [PCW-1:0] pc_eff;
    logic [PCW-1:0] after_pop;
    logic           is_leaf;
    logic           err;
    logic           flag_ok;
    logic           stk_re;
    logic           stk_we;

    // Counts as seen by this byte; a new file starts from zero
    assign n_eff     = i_cmd.clear ? '0 : r_nodes_used;
    assign pc_eff    = i_cmd.clear ? '0 : r_pcount;
    assign n_eff_m1  = n_eff - NUW'(1);
    assign is_leaf   = (i_data == hufd_pkg::LEAF_FLAG);
    assign after_pop = (n_eff == '0) ? '0 : pc_eff - PCW'(1);

    // Overflow checks: table full, no slot to link, stack too shallow
    assign err = (n_eff >= NUW'(NODE_COUNT))
              || ((n_eff != '0) && (pc_eff == '0))
              || (!is_leaf && (({1'b0, after_pop} + (PCW+1)'(2)) > (PCW+1)'(STACK_DEPTH)));

    assign flag_ok = (r_state == H_IDLE) && i_cmd.start && !i_cmd.is_sym && !err;
    assign stk_re  = flag_ok && (n_eff != '0);
    assign stk_we  = (r_state == H_PUSH1) || (r_state == H_PUSH2);

    // Node table write command
    always_comb begin
        o_we     = '0;
        o_waddr  = n_eff[NW-1:0];
        o_wchild = r_node;
        o_wleaf  = is_leaf;
        o_wsym   = i_data;
        if (flag_ok) begin
            o_we.leaf = 1'b1;
        end else if ((r_state == H_IDLE) && i_cmd.start && i_cmd.is_sym && (n_eff != '0)) begin
            o_we.sym = 1'b1;
            o_waddr  = n_eff_m1[NW-1:0];
        end else if (r_state == H_LINK) begin
            o_we.left  = !r_stk_rd[0];
            o_we.right = r_stk_rd[0];
            o_waddr    = r_stk_rd[NW:1];
        end
    end

    // Pending-slot stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[r_pcount[SW-1:0]] <= {r_node, (r_state == H_PUSH1)};
        end
        if (stk_re) begin
            r_stk_rd <= r_stack[after_pop[SW-1:0]];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= H_IDLE;
            r_nodes_used <= '0;
            r_pcount     <= '0;
            r_stat       <= '0;
        end else begin
            r_stat.done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_cmd.start) begin
                        if (i_cmd.is_sym) begin
                            r_nodes_used <= n_eff;
                            r_pcount     <= pc_eff;
                            r_stat       <= '{1'b1, 1'b0,
                                (pc_eff == '0) ? hufd_pkg::PH_DECODE : hufd_pkg::PH_FLAG};
                        end else if (err) begin
                            r_nodes_used <= n_eff;
                            r_pcount     <= pc_eff;
                            r_stat       <= '{1'b1, 1'b1, hufd_pkg::PH_HALT};
                        end else begin
                            r_nodes_used <= n_eff + NUW'(1);
                            r_pcount     <= after_pop;
                            r_node       <= n_eff[NW-1:0];
                            r_leaf       <= is_leaf;
                            if (n_eff != '0) begin
                                r_state <= H_LINK;
                            end else if (is_leaf) begin
                                r_stat <= '{1'b1, 1'b0, hufd_pkg::PH_SYM};
                            end else begin
                                r_state <= H_PUSH1;
                            end
                        end
                    end
                end
                H_LINK: begin
                    if (r_leaf) begin
                        r_state <= H_IDLE;
                        r_stat  <= '{1'b1, 1'b0, hufd_pkg::PH_SYM};
                    end else begin
                        r_state <= H_PUSH1;
                    end
                end
                H_PUSH1: begin
                    r_pcount <= r_pcount + PCW'(1);
                    r_state  <= H_PUSH2;
                end
                H_PUSH2: begin
                    r_pcount <= r_pcount + PCW'(1);
                    r_state  <= H_IDLE;
                    r_stat   <= '{1'b1, 1'b0, hufd_pkg::PH_FLAG};
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_stat = r_stat;

endmodule

// ----- src/huffman_tree_load_and_decode_core.sv -----
// ============================================================================
// huffman_tree_load_and_decode_core
// Huffman decoder for files that carry their code tree as a preorder header.
// ============================================================================
// Coded byte: the walk steps one bit per cycle while no held symbol waits on a
//   stalled output, each step one registered read of the node table.
// Header byte: a symbol byte writes its field; a flag byte below the root reads
//   the stack and links to its parent; an internal node then makes two stack pushes.
// Reset: synchronous, active low; clears phase and counters, tables keep data.
module huffman_tree_load_and_decode_core #(
    parameter int NODE_COUNT  = hufd_pkg::NODE_COUNT_DEF,
    parameter int STACK_DEPTH = hufd_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [hufd_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tuser,   // [0] start_of_file
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [hufd_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] symbol
    output logic                        m_axis_tlast,   // last_of_run
    output logic                        m_axis_tuser    // [0] error
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int BW = hufd_pkg::BYTE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HDR   = 3'd1;
    localparam logic [2:0] S_ERR   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]                    r_state;
    logic [1:0]                    r_phase;
    logic [hufd_pkg::BIT_CNT_W-1:0] r_bit;
    logic [BW-1:0]                 r_shift;
    logic [NW-1:0]                 r_cur_left;
    logic [NW-1:0]                 r_cur_right;
    logic                          r_hold_v;
    logic [BW-1:0]                 r_hold_sym;

    // Root node kept in registers
    logic                          r_root_leaf;
    logic [NW-1:0]                 r_root_left;
    logic [NW-1:0]                 r_root_right;
    logic [BW-1:0]                 r_root_sym;

    // Output word register
    logic                          r_out_valid;
    logic [BW-1:0]                 r_out_sym;
    logic                          r_out_last;
    logic                          r_out_err;

    // Node table
    logic [NW-1:0] r_mem_left  [NODE_COUNT];
    logic [NW-1:0] r_mem_right [NODE_COUNT];
    logic [BW-1:0] r_mem_sym   [NODE_COUNT];
    logic          r_mem_leaf  [NODE_COUNT];
    logic [NW-1:0] r_rd_left;
    logic [NW-1:0] r_rd_right;
    logic [BW-1:0] r_rd_sym;
    logic          r_rd_leaf;

    hufd_pkg::t_hdr_cmd  hdr_cmd;
    hufd_pkg::t_hdr_stat hdr_stat;
    hufd_pkg::t_node_we  node_we;
    logic [NW-1:0]       node_waddr;
    logic [NW-1:0]       node_wchild;
    logic                node_wleaf;
    logic [BW-1:0]       node_wsym;

    logic          in_acc;
    logic [1:0]    eff_phase;
    logic          can_emit;
    logic          hit;
    logic [BW-1:0] hit_sym;
    logic          adv;
    logic [NW-1:0] view_left;
    logic [NW-1:0] view_right;
    logic          rd_en;
    logic [NW-1:0] rd_addr;
    logic          emit_dec;
    logic          emit_flush;
    logic          emit_err;

    // Input handshake and phase seen by the incoming word
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign eff_phase     = s_axis_tuser ? hufd_pkg::PH_FLAG : r_phase;

    assign hdr_cmd.start  = in_acc && ((eff_phase == hufd_pkg::PH_FLAG)
                                    || (eff_phase == hufd_pkg::PH_SYM));
    assign hdr_cmd.clear  = s_axis_tuser;
    assign hdr_cmd.is_sym = (eff_phase == hufd_pkg::PH_SYM);

    hufd_hdr #(
        .NODE_COUNT  (NODE_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_hdr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (hdr_cmd),
        .i_data   (s_axis_tdata),
        .o_stat   (hdr_stat),
        .o_we     (node_we),
        .o_waddr  (node_waddr),
        .o_wchild (node_wchild),
        .o_wleaf  (node_wleaf),
        .o_wsym   (node_wsym)
    );

    // Walk step: node just read, or the root when a leaf was reached
    assign can_emit   = !r_out_valid || m_axis_tready;
    assign hit        = r_root_leaf || r_rd_leaf;
    assign hit_sym    = r_root_leaf ? r_root_sym : r_rd_sym;
    assign adv        = !(hit && r_hold_v && !can_emit);
    assign view_left  = hit ? r_root_left  : r_rd_left;
    assign view_right = hit ? r_root_right : r_rd_right;

    // Next child read: first bit at accept, the rest during the walk
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_shift[BW-1] ? view_right : view_left;
        if (r_state == S_IDLE) begin
            rd_en   = in_acc && (eff_phase == hufd_pkg::PH_DECODE);
            rd_addr = s_axis_tdata[BW-1] ? r_cur_right : r_cur_left;
        end else if (r_state == S_DEC) begin
            rd_en = adv && (r_bit != hufd_pkg::LAST_BIT);
        end
    end

    // Node table memory
    always_ff @(posedge i_clk) begin
        if (node_we.leaf)  r_mem_leaf[node_waddr]  <= node_wleaf;
        if (node_we.left)  r_mem_left[node_waddr]  <= node_wchild;
        if (node_we.right) r_mem_right[node_waddr] <= node_wchild;
        if (node_we.sym)   r_mem_sym[node_waddr]   <= node_wsym;
        if (rd_en) begin
            r_rd_left  <= r_mem_left[rd_addr];
            r_rd_right <= r_mem_right[rd_addr];
            r_rd_sym   <= r_mem_sym[rd_addr];
            r_rd_leaf  <= r_mem_leaf[rd_addr];
        end
    end

    // Root shadow follows every write to node zero
    always_ff @(posedge i_clk) begin
        if (node_waddr == '0) begin
            if (node_we.leaf)  r_root_leaf  <= node_wleaf;
            if (node_we.left)  r_root_left  <= node_wchild;
            if (node_we.right) r_root_right <= node_wchild;
            if (node_we.sym)   r_root_sym   <= node_wsym;
        end
    end

    // Result sources
    assign emit_dec   = (r_state == S_DEC) && hit && r_hold_v && can_emit;
    assign emit_flush = (r_state == S_FLUSH) && r_hold_v && can_emit;
    assign emit_err   = (r_state == S_ERR) && can_emit;

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= hufd_pkg::PH_FLAG;
            r_bit    <= '0;
            r_hold_v <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (eff_phase)
                            hufd_pkg::PH_FLAG, hufd_pkg::PH_SYM: begin
                                r_state <= S_HDR;
                            end
                            hufd_pkg::PH_DECODE: begin
                                r_state <= S_DEC;
                                r_bit   <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_HDR: begin
                    if (hdr_stat.done) begin
                        r_phase <= hdr_stat.phase;
                        r_state <= hdr_stat.error ? S_ERR : S_IDLE;
                    end
                end
                S_ERR: begin
                    if (can_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DEC: begin
                    if (adv) begin
                        if (hit) begin
                            r_hold_v <= 1'b1;
                        end
                        if (r_bit == hufd_pkg::LAST_BIT) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_bit <= r_bit + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_v) begin
                        r_state <= S_IDLE;
                    end else if (can_emit) begin
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Walk data path: shift register, current node, held symbol
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_acc) begin
            r_shift <= {s_axis_tdata[BW-2:0], 1'b0};
        end else if ((r_state == S_DEC) && adv) begin
            r_shift     <= {r_shift[BW-2:0], 1'b0};
            r_cur_left  <= view_left;
            r_cur_right <= view_right;
            if (hit) begin
                r_hold_sym <= hit_sym;
            end
        end else if ((r_state == S_HDR) && hdr_stat.done
                     && (hdr_stat.phase == hufd_pkg::PH_DECODE)) begin
            r_cur_left  <= r_root_left;
            r_cur_right <= r_root_right;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_dec || emit_flush || emit_err) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_err) begin
            r_out_sym  <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end else if (emit_dec || emit_flush) begin
            r_out_sym  <= r_hold_sym;
            r_out_last <= emit_flush;
            r_out_err  <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sym;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    // Error word always closes its run and carries no symbol
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_last && (r_out_sym == '0)))
        else $error("error word without last or with a symbol");

    // A held symbol is always flushed before the next word is taken
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held symbol left behind at end of byte");

    // Overflow emits its error word and halts the file
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ERR) && can_emit)
        |=> ((r_phase == hufd_pkg::PH_HALT) && r_out_valid && r_out_err))
        else $error("overflow did not halt with an error word");

endmodule

// ----- tb/huffman_tree_load_and_decode_core_tb.sv -----
// ============================================================================
// huffman_tree_load_and_decode_core_tb
// Self-checking bench for the preorder-header decoder. Files go in as byte
// words. A scoreboard class rebuilds the code tree from each header, walks
// every coded byte, and queues the symbol and error words due. Each word
// that leaves the core is checked in order against that queue. The run
// covers a lone-leaf root, restarts mid-header and mid-decode, stack and
// node table overflow with the halt that follows, and random files under
// three idle profiles.
// ============================================================================
module huffman_tree_load_and_decode_core_tb;

    import hufd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 40;

    // One output word: symbol, last of run, error flag
    typedef struct packed {
        bit [7:0] symbol;
        bit       last;
        bit       error;
    } sym_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tree builder, bit walker and queue of words still due
    // ------------------------------------------------------------------------
    class symbol_scoreboard;
        bit [8:0]  left_of  [NODE_COUNT_DEF];
        bit [8:0]  right_of [NODE_COUNT_DEF];
        bit [7:0]  sym_of   [NODE_COUNT_DEF];
        bit        leaf_of  [NODE_COUNT_DEF];
        bit [9:0]  open_slots [STACK_DEPTH_DEF];   // node*2 + side, side 1 = right
        int        slot_count;
        int        nodes_used;
        bit [1:0]  phase;
        bit [8:0]  walk_node;
        sym_word_t words_due[$];
        int        bytes_seen;
        int        words_checked;
        int        overflows;
        int        mismatches;

        function new();
            slot_count = 0;
            nodes_used = 0;
            phase      = PH_FLAG;
            walk_node  = '0;
        endfunction

        // Header overflowed: one error word, then ignore until a new file
        function void flag_overflow();
            words_due.push_back('{symbol: 8'h00, last: 1'b1, error: 1'b1});
            phase = PH_HALT;
            overflows++;
        endfunction

        // Node done: tree complete once no child slot is open
        function void close_node();
            if (slot_count == 0) begin
                phase     = PH_DECODE;
                walk_node = '0;
            end else begin
                phase = PH_FLAG;
            end
        endfunction

        // Accepted input word: advance the state and queue its results
        function void take_file_byte(logic [7:0] b, logic sof);
            int       n;
            int       after_pop;
            int       k;
            int       i;
            bit       is_leaf;
            bit [9:0] slot;
            bit [8:0] child;
            bit [7:0] found [8];

            bytes_seen++;
            if (sof) begin
                slot_count = 0;
                nodes_used = 0;
                phase      = PH_FLAG;
                walk_node  = '0;
            end
            case (phase)
                PH_FLAG: begin
                    n         = nodes_used;
                    is_leaf   = (b == LEAF_FLAG);
                    after_pop = (n == 0) ? 0 : slot_count - 1;
                    if (n >= NODE_COUNT_DEF || (n != 0 && slot_count == 0) ||
                        (!is_leaf && after_pop + 2 > STACK_DEPTH_DEF)) begin
                        flag_overflow();
                    end else begin
                        // link the new node into the slot on top of the stack
                        if (n != 0) begin
                            slot       = open_slots[slot_count - 1];
                            slot_count = after_pop;
                            if (slot[0])
                                right_of[slot[9:1]] = 9'(n);
                            else
                                left_of[slot[9:1]] = 9'(n);
                        end
                        left_of[n]  = '0;
                        right_of[n] = '0;
                        sym_of[n]   = '0;
                        leaf_of[n]  = is_leaf;
                        nodes_used  = n + 1;
                        if (is_leaf) begin
                            phase = PH_SYM;
                        end else begin
                            // right slot below left so the left subtree comes first
                            open_slots[slot_count]     = {9'(n), 1'b1};
                            open_slots[slot_count + 1] = {9'(n), 1'b0};
                            slot_count += 2;
                            close_node();
                        end
                    end
                end
                PH_SYM: begin
                    if (nodes_used > 0 && nodes_used <= NODE_COUNT_DEF)
                        sym_of[nodes_used - 1] = b;
                    close_node();
                end
                PH_DECODE: begin
                    // MSB first; a leaf root emits its symbol on every bit
                    k = 0;
                    for (i = 7; i >= 0; i--) begin
                        if (leaf_of[0]) begin
                            found[k] = sym_of[0];
                            k++;
                            walk_node = '0;
                        end else begin
                            child = b[i] ? right_of[walk_node] : left_of[walk_node];
                            if (leaf_of[child]) begin
                                found[k] = sym_of[child];
                                k++;
                                walk_node = '0;
                            end else begin
                                walk_node = child;
                            end
                        end
                    end
                    for (i = 0; i < k; i++)
                        words_due.push_back('{symbol: found[i], last: (i == k - 1),
                                              error: 1'b0});
                end
                default: ;
            endcase
        endfunction

        // Output word: compare with the oldest word due
        function void check_symbol(logic [7:0] sym, logic last, logic err);
            sym_word_t want;
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: sym %02h last %b err %b", sym, last, err);
            end else begin
                want = words_due.pop_front();
                words_checked++;
                if ({want.symbol, want.last, want.error} !== {sym, last, err}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected sym %02h last %b err %b, got sym %02h last %b err %b",
                                 want.symbol, want.last, want.error, sym, last, err);
                end
            end
        endfunction

        function int words_pending();
            return words_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, ports
    // ------------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_axis_tuser  = 1'b0;    // [0] start_of_file
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] symbol
    logic       m_axis_tlast;            // last_of_run
    logic       m_axis_tuser;            // [0] error

    int gap_pct     = 19;
    int stall_pct   = 65;
    int bytes_sent  = 0;
    int cycle_count = 0;

    symbol_scoreboard sb = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    huffman_tree_load_and_decode_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Monitor: inputs noted before outputs checked in the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count++;
            if (s_axis_tvalid && s_axis_tready)
                sb.take_file_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_symbol(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    // Random flag byte that makes an internal node
    function automatic logic [7:0] node_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255, 0));
        if (b == LEAF_FLAG)
            b = ~b;
        return b;
    endfunction

    // One word, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic sof);
        while ($urandom_range(99, 0) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // Stop sending until every word due has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.words_pending() != 0)
            @(posedge i_clk);
    endtask

    // Well-formed file: random tree shape and symbols, then coded bytes
    task automatic send_random_file(input int leaves, input int coded_bytes);
        int   inner_left;
        int   open_cnt;
        logic first;
        inner_left = leaves - 1;
        open_cnt   = 1;
        first      = 1'b1;
        while (open_cnt > 0) begin
            // a leaf on the last open slot would close the tree too early
            if (inner_left > 0 && (open_cnt == 1 || $urandom_range(1, 0) == 1)) begin
                send_byte(node_byte(), first);
                inner_left--;
                open_cnt++;
            end else begin
                send_byte(LEAF_FLAG, first);
                send_byte(8'($urandom_range(255, 0)), 1'b0);
                open_cnt--;
            end
            first = 1'b0;
        end
        repeat (coded_bytes)
            send_byte(8'($urandom_range(255, 0)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int p;
        int goal;
        int pick;
        int leaves;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone-leaf root: eight symbols per coded byte
        send_byte(LEAF_FLAG, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // two leaves under the root, all-zero and all-one fields
        send_byte(8'h00, 1'b1);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // restart while a leaf symbol is expected; symbol equal to the flag
        send_byte(8'hFF, 1'b1);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(LEAF_FLAG, 1'b1);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h5A, 1'b0);

        // restart from decode into a three-leaf tree
        send_byte(8'h01, 1'b1);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'h96, 1'b0);

        // stack overflow: 256 internal nodes in a chain, then ignored bytes
        send_byte(node_byte(), 1'b1);
        repeat (255) send_byte(node_byte(), 1'b0);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // node table full: stack kept near full, 512 nodes, one more flag
        send_byte(node_byte(), 1'b1);
        repeat (254) send_byte(node_byte(), 1'b0);
        repeat (128) begin
            send_byte(LEAF_FLAG, 1'b0);
            send_byte(8'($urandom_range(255, 0)), 1'b0);
            send_byte(node_byte(), 1'b0);
        end
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(LEAF_FLAG, 1'b0);
        send_byte(8'h33, 1'b0);

        // restart out of the halt
        send_random_file(3, 2);
        wait_drained();

        // random files, broken headers and noise under three idle profiles
        for (p = 0; p < 3; p++) begin
            gap_pct   = (p == 0) ? 19 : (p == 1) ? 65 : 0;
            stall_pct = (p == 0) ? 65 : (p == 1) ? 19 : 0;
            goal      = bytes_sent + 60;
            while (bytes_sent < goal) begin
                pick = $urandom_range(99, 0);
                if (pick < 70) begin
                    leaves = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9)
                                                         : $urandom_range(8, 1);
                    send_random_file(leaves, $urandom_range(5, 1));
                end else if (pick < 85) begin
                    // header cut short, next file restarts it
                    send_byte(node_byte(), 1'b1);
                    repeat ($urandom_range(4, 0))
                        send_byte(8'($urandom_range(255, 0)), 1'b0);
                end else begin
                    repeat ($urandom_range(4, 1))
                        send_byte(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d file words: %0d output words checked, %0d header overflows,",
                 sb.bytes_seen, sb.words_checked, sb.overflows);
        $display("across lone-leaf, restart, halt and random-tree files in three idle profiles.");
        if (sb.words_pending() != 0)
            $display("%0d expected words never arrived", sb.words_pending());
        if (sb.mismatches == 0 && sb.words_pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
